// ===== design/lfu_pkg.sv =====
package lfu_pkg;
	localparam int ENTRIES_DEF    = 16;
	localparam int COUNT_BITS_DEF = 16;
	localparam int KEY_W          = 32;
	localparam int VAL_W          = 32;
	localparam int CAP_W          = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic start;
		logic do_write;
	} lfu_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} lfu_stat_t;
endpackage

// ===== design/lfu_if.sv =====
interface lfu_req_if;
	import lfu_pkg::*;
	logic valid;
	logic ready;
	logic op;
	logic signed [KEY_W-1:0] key;
	logic signed [VAL_W-1:0] write_value;
	modport source (output valid, op, key, write_value, input ready);
	modport sink (input valid, op, key, write_value, output ready);
endinterface

interface lfu_rsp_if;
	import lfu_pkg::*;
	logic valid;
	logic ready;
	logic hit;
	logic signed [VAL_W-1:0] read_value;
	logic evicted;
	logic signed [KEY_W-1:0] evicted_key;
	modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
	modport sink (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

// ===== design/lfu_ctrl.sv =====
module lfu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output lfu_pkg::lfu_cmd_t cmd,
	input  lfu_pkg::lfu_stat_t stat
);
	import lfu_pkg::*;
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0] state_q;

	assign req_ready    = (state_q == S_IDLE);
	assign rsp_valid    = (state_q == S_OUT);
	assign cmd.start    = req_valid && req_ready;
	assign cmd.do_write = (state_q == S_RUN) && stat.done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (cmd.start) state_q <= S_RUN;
				S_RUN:  if (stat.done) state_q <= S_OUT;
				S_OUT:  if (rsp_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== design/lfu_dp.sv =====
module lfu_dp #(
	parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [lfu_pkg::CAP_W-1:0]       capacity,
	input  lfu_pkg::lfu_cmd_t               cmd,
	output lfu_pkg::lfu_stat_t              stat,
	input  logic                            in_op,
	input  logic signed [lfu_pkg::KEY_W-1:0] in_key,
	input  logic signed [lfu_pkg::VAL_W-1:0] in_value,
	output logic                            hit,
	output logic signed [lfu_pkg::VAL_W-1:0] read_value,
	output logic                            evicted,
	output logic signed [lfu_pkg::KEY_W-1:0] evicted_key
);
	import lfu_pkg::*;
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int NW = $clog2(ENTRIES + 1);
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	logic                  valid_q [ENTRIES];
	logic [KEY_W-1:0]      key_q   [ENTRIES];
	logic [VAL_W-1:0]      val_q   [ENTRIES];
	logic [COUNT_BITS-1:0] cnt_q   [ENTRIES];
	logic [IW-1:0]         rank_q  [ENTRIES];
	logic [NW-1:0]         occ_q;

	logic              op_q;
	logic [KEY_W-1:0]  k_q;
	logic [VAL_W-1:0]  v_q;
	logic [NW-1:0]     idx_q;
	logic              busy_q;
	logic              found_q, vic_ok_q, free_ok_q;
	logic [IW-1:0]     found_i_q, vic_i_q, free_i_q;

	logic [IW-1:0] ci;
	logic [NW-1:0] eff_cap;
	logic          full;
	logic          do_ev, do_ins;
	logic [IW-1:0] slot;
	logic          slot_free;
	logic [IW-1:0] vr, fr;

	assign ci = idx_q[IW-1:0];
	always_comb begin
		if (capacity == '0) eff_cap = NW'(1);
		else if (32'(capacity) > ENTRIES) eff_cap = NW'(ENTRIES);
		else eff_cap = NW'(capacity);
	end
	assign full      = (occ_q >= eff_cap);
	assign do_ev     = !found_q && op_q && full && vic_ok_q;
	assign slot      = do_ev ? vic_i_q : free_i_q;
	assign slot_free = do_ev || free_ok_q;
	assign do_ins    = !found_q && op_q && slot_free;
	assign vr        = rank_q[vic_i_q];
	assign fr        = rank_q[found_i_q];
	assign stat.busy = busy_q;
	assign stat.done = busy_q && (idx_q == NW'(ENTRIES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			occ_q       <= '0;
			idx_q       <= '0;
			op_q        <= 1'b0;
			k_q         <= '0;
			v_q         <= '0;
			found_q     <= 1'b0;
			vic_ok_q    <= 1'b0;
			free_ok_q   <= 1'b0;
			found_i_q   <= '0;
			vic_i_q     <= '0;
			free_i_q    <= '0;
			hit         <= 1'b0;
			read_value  <= '0;
			evicted     <= 1'b0;
			evicted_key <= '0;
			for (int j = 0; j < ENTRIES; j++) begin
				valid_q[j] <= 1'b0;
				key_q[j]   <= '0;
				val_q[j]   <= '0;
				cnt_q[j]   <= '0;
				rank_q[j]  <= '0;
			end
		end else if (cmd.start) begin
			busy_q   <= 1'b1;
			idx_q    <= '0;
			op_q     <= in_op;
			k_q      <= in_key;
			v_q      <= in_value;
			found_q  <= 1'b0;
			vic_ok_q <= 1'b0;
			free_ok_q <= 1'b0;
		end else if (busy_q && !stat.done) begin
			idx_q <= idx_q + 1'b1;
			if (valid_q[ci]) begin
				if (!found_q && key_q[ci] == k_q) begin
					found_q   <= 1'b1;
					found_i_q <= ci;
				end
				if (!vic_ok_q || cnt_q[ci] < cnt_q[vic_i_q] ||
				    (cnt_q[ci] == cnt_q[vic_i_q] && rank_q[ci] > rank_q[vic_i_q])) begin
					vic_ok_q <= 1'b1;
					vic_i_q  <= ci;
				end
			end else if (!free_ok_q) begin
				free_ok_q <= 1'b1;
				free_i_q  <= ci;
			end
		end else if (cmd.do_write) begin
			busy_q      <= 1'b0;
			hit         <= found_q;
			read_value  <= (found_q && op_q == OP_GET) ? val_q[found_i_q] : '0;
			evicted     <= do_ev;
			evicted_key <= do_ev ? key_q[vic_i_q] : '0;
			if (found_q) begin
				for (int j = 0; j < ENTRIES; j++)
					if (valid_q[j] && rank_q[j] < fr) rank_q[j] <= rank_q[j] + 1'b1;
				rank_q[found_i_q] <= '0;
				if (cnt_q[found_i_q] != CMAX) cnt_q[found_i_q] <= cnt_q[found_i_q] + 1'b1;
				if (op_q == OP_PUT) val_q[found_i_q] <= v_q;
			end else if (do_ins) begin
				for (int j = 0; j < ENTRIES; j++)
					if (valid_q[j] && (!do_ev || rank_q[j] < vr))
						rank_q[j] <= rank_q[j] + 1'b1;
				valid_q[slot] <= 1'b1;
				key_q[slot]   <= k_q;
				val_q[slot]   <= v_q;
				cnt_q[slot]   <= COUNT_BITS'(1);
				rank_q[slot]  <= '0;
				if (!do_ev) occ_q <= occ_q + 1'b1;
			end
		end
	end
endmodule

// ===== design/lfu_cache_core.sv =====
// LFU key-value cache with LRU tie break. One request at a time: the
// datapath scans all ENTRIES slots one per cycle to find the key, the
// lowest-count oldest victim and a free slot, then commits the update and
// registers the response. A new request is taken only after the response
// has been taken. A response stays until taken.
module lfu_cache_core #(
	parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]   cfg_wdata,
	lfu_req_if.sink                     req,
	lfu_rsp_if.source                   rsp
);
	import lfu_pkg::*;
	logic [CAP_W-1:0] cap_q;
	lfu_cmd_t  cmd;
	lfu_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cap_q <= CAP_RESET;
		else if (cfg_we) cap_q <= cfg_wdata;
	end

	lfu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_ready(req.ready),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
		.cmd(cmd), .stat(stat)
	);

	lfu_dp #(.ENTRIES(ENTRIES), .COUNT_BITS(COUNT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .capacity(cap_q), .cmd(cmd), .stat(stat),
		.in_op(req.op), .in_key(req.key), .in_value(req.write_value),
		.hit(rsp.hit), .read_value(rsp.read_value),
		.evicted(rsp.evicted), .evicted_key(rsp.evicted_key)
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.busy |-> !req.ready) else $error("request accepted while busy");
	a_rsp_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(stat.done)) else $error("response without scan");
	a_evict_put: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.evicted |-> !rsp.hit) else $error("eviction on hit");
endmodule

// ===== tb/lfu_tb_scoreboard.sv =====
package lfu_tb_scoreboard_pkg;
	import lfu_pkg::*;

	typedef struct packed {
		logic hit;
		logic [VAL_W-1:0] read_value;
		logic evicted;
		logic [KEY_W-1:0] evicted_key;
	} lfu_result_t;

	class lfu_scoreboard;
		localparam int N = ENTRIES_DEF;
		localparam logic [COUNT_BITS_DEF-1:0] USE_MAX = '1;

		bit entry_valid[N];
		logic [KEY_W-1:0] entry_key[N];
		logic [VAL_W-1:0] entry_value[N];
		logic [COUNT_BITS_DEF-1:0] entry_uses[N];
		int unsigned entry_age[N];
		int unsigned occupancy;
		logic [CAP_W-1:0] capacity;
		lfu_result_t pending_results[$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned hits;
		int unsigned evictions;

		function new();
			for (int i = 0; i < N; i++) begin
				entry_valid[i] = 0;
				entry_key[i] = '0;
				entry_value[i] = '0;
				entry_uses[i] = '0;
				entry_age[i] = 0;
			end
			occupancy = 0;
			capacity = CAP_RESET;
			mismatches = 0;
			checked = 0;
			hits = 0;
			evictions = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] c);
			capacity = c;
		endfunction

		function int unsigned usable_capacity();
			int unsigned c;
			c = capacity;
			if (c < 1) c = 1;
			if (c > N) c = N;
			return c;
		endfunction

		function void touch_entry(int i);
			for (int j = 0; j < N; j++)
				if (j != i && entry_valid[j] && entry_age[j] < entry_age[i])
					entry_age[j]++;
			entry_age[i] = 0;
			if (entry_uses[i] != USE_MAX)
				entry_uses[i]++;
		endfunction

		function void note_request(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] wval);
			lfu_result_t r;
			int found;
			int victim;
			int slot;
			r = '0;
			found = -1;
			for (int i = 0; i < N; i++)
				if (found < 0 && entry_valid[i] && entry_key[i] == key)
					found = i;
			if (found >= 0) begin
				r.hit = 1;
				if (op == OP_PUT)
					entry_value[found] = wval;
				else
					r.read_value = entry_value[found];
				touch_entry(found);
			end else if (op == OP_PUT) begin
				if (occupancy >= usable_capacity() || occupancy >= N) begin
					victim = -1;
					for (int i = 0; i < N; i++) begin
						if (!entry_valid[i]) continue;
						if (victim < 0 || entry_uses[i] < entry_uses[victim] ||
							(entry_uses[i] == entry_uses[victim] &&
							entry_age[i] > entry_age[victim]))
							victim = i;
					end
					if (victim >= 0) begin
						r.evicted = 1;
						r.evicted_key = entry_key[victim];
						entry_valid[victim] = 0;
						for (int i = 0; i < N; i++)
							if (entry_valid[i] && entry_age[i] > entry_age[victim])
								entry_age[i]--;
						if (occupancy > 0) occupancy--;
					end
				end
				slot = -1;
				for (int i = 0; i < N; i++)
					if (slot < 0 && !entry_valid[i])
						slot = i;
				if (slot >= 0) begin
					for (int i = 0; i < N; i++)
						if (entry_valid[i])
							entry_age[i]++;
					entry_valid[slot] = 1;
					entry_key[slot] = key;
					entry_value[slot] = wval;
					entry_uses[slot] = 1;
					entry_age[slot] = 0;
					occupancy++;
				end
			end
			pending_results.push_back(r);
		endfunction

		function void check_result(lfu_result_t got);
			lfu_result_t want;
			checked++;
			if (got.hit) hits++;
			if (got.evicted) evictions++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected response %p", got);
				return;
			end
			want = pending_results.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: response %0d hit %b/%b rd %h/%h ev %b/%b evk %h/%h",
						checked, want.hit, got.hit, want.read_value, got.read_value,
						want.evicted, got.evicted, want.evicted_key, got.evicted_key);
			end
		endfunction
	endclass
endpackage

// ===== tb/lfu_cache_core_tb.sv =====
module lfu_cache_core_tb;
	import lfu_pkg::*;
	import lfu_tb_scoreboard_pkg::*;

	localparam int TIMEOUT_CYCLES = 400000;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CAP_W-1:0] cfg_wdata;
	int unsigned cycle_count;
	bit hold_rsp;
	int unsigned sent;

	lfu_req_if req();
	lfu_rsp_if rsp();
	lfu_scoreboard sb;

	lfu_cache_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req.sink),
		.rsp      (rsp.source)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count > TIMEOUT_CYCLES) begin
				$display("Timeout after %0d cycles", cycle_count);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic send_request(logic op, logic [KEY_W-1:0] key, logic [VAL_W-1:0] wval);
		int gap;
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			req.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1;
		req.op <= op;
		req.key <= key;
		req.write_value <= wval;
		do @(posedge clk); while (!req.ready);
		sb.note_request(op, key, wval);
		sent++;
	endtask

	task automatic drain();
		req.valid <= 0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] c);
		drain();
		cfg_we <= 1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 0;
		sb.set_capacity(c);
	endtask

	function automatic logic [KEY_W-1:0] pick_key(int pool);
		if ($urandom_range(0, 9) == 0) return $urandom();
		return KEY_W'($urandom_range(0, pool)) ^ 32'h8000_0000 * $urandom_range(0, 1);
	endfunction

	task automatic random_phase(int count, int pool);
		for (int n = 0; n < count; n++)
			send_request($urandom_range(0, 1) ? OP_PUT : OP_GET, pick_key(pool), $urandom());
	endtask

	// response side
	initial begin
		int gap;
		rsp.ready = 0;
		@(posedge arst_n);
		forever begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
			if (hold_rsp) gap = 300;
			if (gap > 0) begin
				rsp.ready <= 0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1;
			do @(posedge clk); while (!rsp.valid);
			sb.check_result('{rsp.hit, rsp.read_value, rsp.evicted, rsp.evicted_key});
		end
	end

	initial begin
		sb = new();
		req.valid = 0;
		req.op = OP_GET;
		req.key = '0;
		req.write_value = '0;
		cfg_we = 0;
		cfg_wdata = '0;
		hold_rsp = 0;
		sent = 0;
		arst_n = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_request(OP_GET, 32'h0, 32'h0);
		send_request(OP_PUT, 32'h8000_0000, 32'h7fff_ffff);
		send_request(OP_PUT, 32'h7fff_ffff, 32'h8000_0000);
		send_request(OP_PUT, 32'hffff_ffff, 32'hffff_ffff);
		send_request(OP_GET, 32'h8000_0000, 32'h1234_5678);
		send_request(OP_GET, 32'h7fff_ffff, 32'h0);
		send_request(OP_PUT, 32'h7fff_ffff, 32'h0);
		send_request(OP_GET, 32'h1, 32'h0);
		for (int k = 0; k < 16; k++)
			send_request(OP_PUT, 32'h100 + k, $urandom());

		write_capacity(5'd1);
		random_phase(40, 4);
		write_capacity(5'd0);
		random_phase(30, 3);
		write_capacity(5'd31);
		random_phase(120, 24);
		write_capacity(5'd3);
		random_phase(60, 6);
		write_capacity(5'd16);
		hold_rsp = 1;
		random_phase(20, 20);
		hold_rsp = 0;
		drain();
		write_capacity(5'd8);
		random_phase(150, 14);
		write_capacity(5'd17);
		random_phase(150, 30);
		write_capacity(5'd12);
		random_phase(250, 18);

		drain();
		$display("Sent %0d requests, checked %0d responses (%0d hits, %0d evictions)",
			sent, sb.checked, sb.hits, sb.evictions);
		$display("Capacities 0, 1, 3, 8, 12, 16, 17 and 31 used; %0d mismatches",
			sb.mismatches);
		if (sb.mismatches == 0 && sb.pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
